// ===== rtl/tfp_pkg.sv =====
// shared constants, codes and frame descriptor type for the touch frame parser
package tfp_pkg;

  localparam int FRAME_LEN  = 26;
  localparam int MAX_POINTS = 5;

  localparam int CNT_W     = 6;
  localparam int COUNT_MAX = 63;
  localparam int PB_FIRST  = 5;
  localparam int PB_COUNT  = 20;

  localparam logic [7:0] HDR_BYTE = 8'hAA;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_PROTO = 2'd2;
  localparam logic [1:0] STAT_CSUM  = 2'd3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int IDX_W = 3;

  typedef logic [11:0] coord_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic [2:0]                   count;
    coord_t [MAX_POINTS-1:0]      x;
    coord_t [MAX_POINTS-1:0]      y;
  } frame_desc_t;

endpackage

// ===== rtl/touch_frame_parser.sv =====
// top level of the touch frame parser: front end, descriptor queue, back end
// takes one byte per cycle; s_tready drops only while the descriptor queue is full
// the checksum byte pushes the descriptor into the queue; from an empty queue the first result is then registered out
// results leave one per cycle while m_tready allows: max(1, point count) results per frame from the back end
// rst is synchronous: clears frame tracking, queue pointers and output valid
module touch_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_frame
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [1:0] status, [4:2] point_count, [7:5] point_index,
                                 // [19:8] point_x, [31:20] point_y
  output logic [0:0]  m_tuser,   // [0] point_valid
  output logic        m_tlast    // last
);
  import tfp_pkg::*;

  frame_desc_t       wr_desc;
  frame_desc_t       head;
  logic              push;
  logic              pop;
  logic              q_empty;
  logic              q_full;
  logic [QCNT_W-1:0] q_count;

  tfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .desc     (wr_desc)
  );

  tfp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_desc (wr_desc),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full),
    .count   (q_count)
  );

  tfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // a result without a point is always the only one of its frame
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("point-less result not marked last");

  // point index stays below the reported count
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[7:5] < m_tdata[4:2]))
    else $error("point index out of range");

  // short or malformed frames never report points
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == STAT_SHORT || m_tdata[1:0] == STAT_PROTO)
      |-> (m_tdata[4:2] == 3'd0) && !m_tuser[0])
    else $error("points reported on rejected frame");

  // queue occupancy never passes its depth and no push lands on a full queue
  assert property (@(posedge clk) disable iff (rst)
    (q_count <= QCNT_W'(QDEPTH)) && !(push && q_full))
    else $error("descriptor queue overflow");

endmodule

// ===== rtl/tfp_front.sv =====
// front end: takes report bytes, tracks header/length/xor and point bytes, builds frame descriptor
module tfp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // data_byte
  input  logic                 s_tlast,   // end_of_frame
  input  logic                 q_full,
  output logic                 push,
  output tfp_pkg::frame_desc_t desc
);
  import tfp_pkg::*;

  logic [CNT_W-1:0] byte_count;
  logic             header_good;
  logic             length_good;
  logic [3:0]       points_nibble;
  logic [7:0]       running_xor;
  logic [7:0]       pb [PB_COUNT];

  logic accept;
  logic too_short;
  logic proto_bad;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      header_good   <= 1'b1;
      length_good   <= 1'b0;
      points_nibble <= '0;
      running_xor   <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        byte_count    <= '0;
        header_good   <= 1'b1;
        length_good   <= 1'b0;
        points_nibble <= '0;
        running_xor   <= '0;
      end else begin
        if ((byte_count == CNT_W'(0) || byte_count == CNT_W'(1)) && s_tdata != HDR_BYTE) begin
          header_good <= 1'b0;
        end
        if (byte_count == CNT_W'(2)) begin
          length_good <= (s_tdata[5:0] == 6'(FRAME_LEN));
        end
        if (byte_count == CNT_W'(3)) begin
          points_nibble <= s_tdata[3:0];
        end
        running_xor <= running_xor ^ s_tdata;
        if (byte_count != CNT_W'(COUNT_MAX)) begin
          byte_count <= byte_count + CNT_W'(1);
        end
      end
    end
  end

  // each point byte register sits at a fixed frame position
  always_ff @(posedge clk) begin
    if (accept && !s_tlast) begin
      for (int k = 0; k < PB_COUNT; k++) begin
        if (byte_count == CNT_W'(PB_FIRST + k)) begin
          pb[k] <= s_tdata;
        end
      end
    end
  end

  assign too_short = (byte_count < CNT_W'(FRAME_LEN - 1));
  assign proto_bad = !header_good || !length_good || (points_nibble > 4'(MAX_POINTS));

  always_comb begin
    desc = '0;
    if (too_short) begin
      desc.status = STAT_SHORT;
    end else if (proto_bad) begin
      desc.status = STAT_PROTO;
    end else begin
      desc.count  = points_nibble[2:0];
      desc.status = (running_xor != s_tdata) ? STAT_CSUM : STAT_OK;
    end
    for (int i = 0; i < MAX_POINTS; i++) begin
      desc.x[i] = {pb[4*i][3:0], pb[4*i+1]};
      desc.y[i] = {pb[4*i+2][3:0], pb[4*i+3]};
    end
  end

endmodule

// ===== rtl/tfp_queue.sv =====
// short descriptor queue between front and back ends
module tfp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tfp_pkg::frame_desc_t wr_desc,
  input  logic                 pop,
  output tfp_pkg::frame_desc_t head,
  output logic                 empty,
  output logic                 full,
  output logic [tfp_pkg::QCNT_W-1:0] count
);
  import tfp_pkg::*;

  frame_desc_t       entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign empty = (count == QCNT_W'(0));
  assign full  = (count == QCNT_W'(QDEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/tfp_back.sv =====
// back end: walks the points of the head descriptor into the output register
module tfp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  tfp_pkg::frame_desc_t head,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,   // status, point_count, point_index, point_x, point_y
  output logic [0:0]           m_tuser,   // point_valid
  output logic                 m_tlast    // last
);
  import tfp_pkg::*;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] final_idx;
  logic             load;
  logic             is_last;
  logic             has_points;
  coord_t           sel_x;
  coord_t           sel_y;

  assign has_points = (head.count != 3'd0);
  assign final_idx  = has_points ? IDX_W'(head.count - 3'd1) : '0;
  assign is_last    = (idx == final_idx);
  assign load       = !q_empty && (!m_tvalid || m_tready);
  assign pop        = load && is_last;

  always_comb begin
    sel_x = '0;
    sel_y = '0;
    if (has_points) begin
      sel_x = head.x[idx];
      sel_y = head.y[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= is_last ? '0 : idx + IDX_W'(1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata    <= {sel_y, sel_x, 3'(idx), head.count, head.status};
      m_tuser[0] <= has_points;
      m_tlast    <= is_last;
    end
  end

endmodule

// ===== tb/sv/touch_frame_parser_tb.sv =====
// self-checking testbench for the touch frame parser: frame stimulus, parse prediction, result check
`timescale 1ns / 1ps

module touch_frame_parser_tb;
  import tfp_pkg::*;

  localparam int STALL_LIMIT = 500;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  count;
    logic [2:0]  index;
    logic        valid;
    logic [11:0] x;
    logic [11:0] y;
    logic        last;
  } touch_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  touch_frame_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // parser state as the testbench tracks it
  logic [5:0] seen_bytes = '0;
  logic       hdr_ok = 1'b1;
  logic       len_ok = 1'b0;
  logic [3:0] pts_nibble = '0;
  logic [7:0] xor_acc = '0;
  logic [7:0] pt_bytes [PB_COUNT];

  touch_result_t pending_points[$];
  logic [7:0]    frame_bytes[$];

  bit idle_on = 1'b1;
  int bytes_taken = 0;
  int results_predicted = 0;
  int points_checked = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  function automatic void parse_byte(logic [7:0] b, logic eof);
    touch_result_t r;
    logic [1:0]    st;
    int            npts;
    if (!eof) begin
      if (seen_bytes < 2 && b != HDR_BYTE) hdr_ok = 1'b0;
      if (seen_bytes == 2) len_ok = (b[5:0] == FRAME_LEN);
      if (seen_bytes == 3) pts_nibble = b[3:0];
      if (seen_bytes >= PB_FIRST && seen_bytes < PB_FIRST + PB_COUNT)
        pt_bytes[seen_bytes - PB_FIRST] = b;
      xor_acc ^= b;
      if (seen_bytes != COUNT_MAX) seen_bytes++;
      return;
    end
    npts = 0;
    if (int'(seen_bytes) + 1 < FRAME_LEN) begin
      st = STAT_SHORT;
    end else if (!hdr_ok || !len_ok || pts_nibble > MAX_POINTS) begin
      st = STAT_PROTO;
    end else begin
      npts = pts_nibble;
      st = (xor_acc != b) ? STAT_CSUM : STAT_OK;
    end
    if (npts == 0) begin
      r = '0;
      r.status = st;
      r.last = 1'b1;
      pending_points.push_back(r);
    end else begin
      for (int i = 0; i < npts; i++) begin
        r.status = st;
        r.count  = 3'(npts);
        r.index  = 3'(i);
        r.valid  = 1'b1;
        // upper nibble of each high byte is dropped
        r.x      = {pt_bytes[4*i][3:0], pt_bytes[4*i+1]};
        r.y      = {pt_bytes[4*i+2][3:0], pt_bytes[4*i+3]};
        r.last   = (i == npts - 1);
        pending_points.push_back(r);
      end
    end
    results_predicted += (npts == 0) ? 1 : npts;
    status_seen[st]++;
    seen_bytes = '0;
    hdr_ok     = 1'b1;
    len_ok     = 1'b0;
    pts_nibble = '0;
    xor_acc    = '0;
  endfunction

  // predict on accepted bytes, then check accepted results, both at the same edge
  always @(posedge clk) begin
    touch_result_t got;
    touch_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, s_tlast);
        bytes_taken++;
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[1:0], m_tdata[4:2], m_tdata[7:5], m_tuser[0],
               m_tdata[19:8], m_tdata[31:20], m_tlast};
        if (pending_points.size() == 0) begin
          $display("%0t: unexpected word: st=%0d cnt=%0d idx=%0d v=%0d x=%h y=%h last=%0d",
                   $time, got.status, got.count, got.index, got.valid, got.x, got.y, got.last);
          mismatch_count++;
        end else begin
          want = pending_points.pop_front();
          if (got.status !== want.status || got.count !== want.count ||
              got.index !== want.index || got.valid !== want.valid ||
              got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
            $display("%0t: mismatch exp st=%0d cnt=%0d idx=%0d v=%0d x=%h y=%h last=%0d",
                     $time, want.status, want.count, want.index, want.valid, want.x,
                     want.y, want.last);
            $display("%0t:          act st=%0d cnt=%0d idx=%0d v=%0d x=%h y=%h last=%0d",
                     $time, got.status, got.count, got.index, got.valid, got.x, got.y,
                     got.last);
            mismatch_count++;
          end
          points_checked++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, stall_cycles, pending_points.size());
        $display("FAIL touch_frame_parser");
        $finish;
      end
    end
  end

  // result side backpressure in random bursts while idle_on is set
  initial begin : sink_ready
    int n;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 11);
      end else begin
        m_tready <= 1'b1;
        n = $urandom_range(1, 16);
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // header, length field, point nibble, then random body, without the checksum word
  task automatic open_frame(input int npts_field, input int total_len);
    frame_bytes.delete();
    for (int i = 0; i < total_len - 1; i++) begin
      case (i)
        0, 1:    frame_bytes.push_back(HDR_BYTE);
        2:       frame_bytes.push_back({2'($urandom_range(0, 3)), 6'(FRAME_LEN)});
        3:       frame_bytes.push_back({4'($urandom), 4'(npts_field)});
        default: frame_bytes.push_back(8'($urandom));
      endcase
    end
  endtask

  task automatic close_frame(input bit csum_ok);
    logic [7:0] sum;
    sum = '0;
    foreach (frame_bytes[i]) sum ^= frame_bytes[i];
    if (!csum_ok) sum ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(sum);
  endtask

  task automatic random_frame();
    int         kind;
    int         npts;
    bit         csum_ok;
    logic [7:0] b;
    logic [5:0] len_field;
    kind    = $urandom_range(0, 99);
    csum_ok = ($urandom_range(0, 4) != 0);
    npts    = $urandom_range(0, MAX_POINTS);
    if (kind < 55) begin
      open_frame(npts, FRAME_LEN);
    end else if (kind < 62) begin
      // overlong, the longer ones saturate the byte count
      open_frame(npts, $urandom_range(FRAME_LEN + 1, 70));
    end else if (kind < 70) begin
      open_frame(npts, FRAME_LEN);
      do b = 8'($urandom); while (b == HDR_BYTE);
      frame_bytes[$urandom_range(0, 1)] = b;
    end else if (kind < 77) begin
      open_frame(npts, FRAME_LEN);
      do len_field = 6'($urandom); while (len_field == FRAME_LEN);
      frame_bytes[2] = {2'($urandom), len_field};
    end else if (kind < 84) begin
      open_frame($urandom_range(MAX_POINTS + 1, 15), FRAME_LEN);
    end else if (kind < 94) begin
      open_frame(npts, $urandom_range(1, FRAME_LEN - 1));
    end else begin
      frame_bytes.delete();
      repeat ($urandom_range(0, 40)) frame_bytes.push_back(8'($urandom));
    end
    close_frame(csum_ok);
    send_frame();
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
  endtask

  task automatic test_lone_checksum();
    open_frame(0, 1);
    close_frame($urandom_range(0, 1));
    send_frame();
  endtask

  task automatic test_point_extremes();
    open_frame(MAX_POINTS, FRAME_LEN);
    frame_bytes[2] = {2'b11, 6'(FRAME_LEN)};
    frame_bytes[3] = {4'hF, 4'(MAX_POINTS)};
    frame_bytes[4] = 8'hFF;
    for (int i = 0; i < 4; i++) begin
      frame_bytes[PB_FIRST + i]     = 8'hFF;
      frame_bytes[PB_FIRST + 4 + i] = 8'h00;
    end
    // third point: x high byte with only the dropped nibble set, x low byte full; y high byte 0x0F, y low byte zero
    frame_bytes[PB_FIRST + 8]  = 8'hF0;
    frame_bytes[PB_FIRST + 9]  = 8'hFF;
    frame_bytes[PB_FIRST + 10] = 8'h0F;
    frame_bytes[PB_FIRST + 11] = 8'h00;
    close_frame(1'b1);
    send_frame();
  endtask

  task automatic test_random_frames(input int byte_budget);
    int bytes_at_start;
    bytes_at_start = bytes_taken;
    while (bytes_taken - bytes_at_start < byte_budget)
      random_frame();
  endtask

  task automatic test_drain_pause();
    repeat (2) begin
      random_frame();
      wait_drained();
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (2) random_frame();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_lone_checksum();
    test_point_extremes();
    test_random_frames(30);
    test_drain_pause();
    test_random_frames(30);
    test_back_to_back();
    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d input words, %0d results expected, %0d results checked",
             bytes_taken, results_predicted, points_checked);
    $display("frame status mix: ok %0d, short %0d, protocol %0d, checksum %0d",
             status_seen[STAT_OK], status_seen[STAT_SHORT], status_seen[STAT_PROTO],
             status_seen[STAT_CSUM]);
    if (mismatch_count == 0) begin
      $display("PASS touch_frame_parser");
    end else begin
      $display("FAIL touch_frame_parser");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tfp_pkg.sv
rtl/tfp_front.sv
rtl/tfp_queue.sv
rtl/tfp_back.sv
rtl/touch_frame_parser.sv
tb/sv/touch_frame_parser_tb.sv
